>>> hdl/abpd_pkg.sv
// ----------------------------------------------------------------------------
// abpd_pkg: shared types and constants of the ASK bi-phase packet decoder
// Holds the width classes, the decoder phases, the result layout and the
// register map used by the front, the queue, the back and the top level.
// ----------------------------------------------------------------------------
package abpd_pkg;

	localparam int MAX_PACKET_BYTES = 29;

	// Register map of the configuration channel.
	typedef enum logic [2:0] {
		R_ZERO_MAX   = 3'd0,
		R_ZERO_MIN   = 3'd1,
		R_START_MIN  = 3'd2,
		R_HALF_MAX   = 3'd3,
		R_HALF_MIN   = 3'd4,
		R_PRE_MIN    = 3'd5,
		R_PRE_MAX    = 3'd6
	} reg_idx_t;

	localparam logic [15:0] ZERO_MAX_RST  = 16'd900;
	localparam logic [15:0] ZERO_MIN_RST  = 16'd450;
	localparam logic [15:0] START_MIN_RST = 16'd405;
	localparam logic [15:0] HALF_MAX_RST  = 16'd337;
	localparam logic [15:0] HALF_MIN_RST  = 16'd99;
	localparam logic [5:0]  PRE_MIN_RST   = 6'd5;
	localparam logic [5:0]  PRE_MAX_RST   = 6'd50;

	// Width thresholds seen by the classifier.
	typedef struct packed {
		logic [15:0] zero_max;
		logic [15:0] zero_min;
		logic [15:0] start_min;
		logic [15:0] half_max;
		logic [15:0] half_min;
	} wcfg_t;

	typedef enum logic [2:0] {
		CL_LONG  = 3'd0,
		CL_ZERO  = 3'd1,
		CL_UNC   = 3'd2,
		CL_HALF  = 3'd3,
		CL_SHORT = 3'd4
	} wclass_t;

	// One classified interval as it travels through the queue.
	typedef struct packed {
		wclass_t cls;
		logic    above_start;
	} cls_t;

	typedef enum logic [3:0] {
		BP_START  = 4'b0001,
		BP_DATA   = 4'b0010,
		BP_PARITY = 4'b0100,
		BP_STOP   = 4'b1000
	} bphase_t;

	typedef enum logic [3:0] {
		PP_PRE = 4'b0001,
		PP_HDR = 4'b0010,
		PP_MSG = 4'b0100,
		PP_CHK = 4'b1000
	} pphase_t;

	typedef enum logic [1:0] {
		K_HDR  = 2'd0,
		K_BYTE = 2'd1,
		K_GOOD = 2'd2,
		K_ERR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE   = 3'd0,
		E_LONG   = 3'd1,
		E_SHORT  = 3'd2,
		E_HALF   = 3'd3,
		E_START  = 3'd4,
		E_PARITY = 3'd5,
		E_STOP   = 3'd6,
		E_PRECHK = 3'd7
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  val;
		logic [4:0]  idx;
		logic [4:0]  len;
		logic [7:0]  hdr;
		err_t        code;
		logic        last;
	} res_t;

endpackage

>>> hdl/ask_biphase_packet_decoder.sv
// ----------------------------------------------------------------------------
// ask_biphase_packet_decoder: ASK differential bi-phase packet decoder
// Decodes edge intervals into preamble, framed bytes and checked packets.
// ----------------------------------------------------------------------------
// An interval is classified in the cycle it is accepted and is queued; the
// back decodes it when it pops it and registers its result beats in the
// result buffer, from which they are offered. One interval per cycle when
// each gives at most one result and every beat is taken; an interval with
// more results (up to 4) holds the result buffer until they are all taken.
// Reset: arst_n clears the queue, the decoder state and the result buffer
// at once and loads the threshold registers with their default values.
module ask_biphase_packet_decoder import abpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] interval_count
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] byte_value, [12:8] byte_index, [17:13] packet_length,
	// [25:18] header_byte, [28:26] error_code, [31:29] zero
	output logic [31:0] m_tdata,
	output logic [1:0]  m_tuser,    // [1:0] kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Threshold registers. The configuration channel is always ready; an
	// index past the end of the register map is taken and ignored.
	wcfg_t      wcfg_q;
	logic [5:0] pre_min_q;
	logic [5:0] pre_max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcfg_q.zero_max  <= ZERO_MAX_RST;
			wcfg_q.zero_min  <= ZERO_MIN_RST;
			wcfg_q.start_min <= START_MIN_RST;
			wcfg_q.half_max  <= HALF_MAX_RST;
			wcfg_q.half_min  <= HALF_MIN_RST;
			pre_min_q        <= PRE_MIN_RST;
			pre_max_q        <= PRE_MAX_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				R_ZERO_MAX:  wcfg_q.zero_max  <= cfg_data;
				R_ZERO_MIN:  wcfg_q.zero_min  <= cfg_data;
				R_START_MIN: wcfg_q.start_min <= cfg_data;
				R_HALF_MAX:  wcfg_q.half_max  <= cfg_data;
				R_HALF_MIN:  wcfg_q.half_min  <= cfg_data;
				R_PRE_MIN:   pre_min_q        <= cfg_data[5:0];
				R_PRE_MAX:   pre_max_q        <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	// The front classifies each interval by width; the queue lets it keep
	// taking intervals while the back is still handing out result beats.
	logic q_full;
	logic q_push;
	cls_t q_push_data;
	logic q_pop;
	cls_t q_pop_data;
	logic q_empty;

	abpd_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.wcfg     (wcfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_push_data)
	);

	abpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.empty     (q_empty)
	);

	// The back resolves pending halves into bits, frames bytes, assembles
	// the packet and buffers the results of one interval.
	abpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pre_min  (pre_min_q),
		.pre_max  (pre_max_q),
		.q_empty  (q_empty),
		.q_data   (q_pop_data),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// An error always ends the interval, so its beat is the last one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == K_ERR) |-> m_tlast)
		else $error("error result is not the last beat of its interval");

	// Only error results carry an error code.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == K_ERR) == (m_tdata[28:26] != E_NONE)))
		else $error("error code does not match result kind");

	// The back never pops an empty queue and the front never pushes a full one.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty) && !(q_push && q_full))
		else $error("queue overrun or underrun");

endmodule

>>> hdl/abpd_front.sv
// ----------------------------------------------------------------------------
// abpd_front: interval classifier
// Sorts each accepted interval into one width class against the thresholds.
// ----------------------------------------------------------------------------
module abpd_front import abpd_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] interval_count
	input  wcfg_t       wcfg,
	input  logic        q_full,
	output logic        q_push,
	output cls_t        q_data
);

	logic [15:0] w;

	assign w        = s_tdata;
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// The tests run in a fixed order whatever the threshold values are.
	always_comb begin
		q_data.above_start = (w > wcfg.start_min);
		if (w > wcfg.zero_max) begin
			q_data.cls = CL_LONG;
		end else if (w >= wcfg.zero_min) begin
			q_data.cls = CL_ZERO;
		end else if (w >= wcfg.half_max) begin
			q_data.cls = CL_UNC;
		end else if (w >= wcfg.half_min) begin
			q_data.cls = CL_HALF;
		end else begin
			q_data.cls = CL_SHORT;
		end
	end

endmodule

>>> hdl/abpd_queue.sv
// ----------------------------------------------------------------------------
// abpd_queue: two-entry queue of classified intervals
// Decouples the classifier from the bit decoder.
// ----------------------------------------------------------------------------
module abpd_queue import abpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_data,
	output logic full,
	input  logic pop,
	output cls_t pop_data,
	output logic empty
);

	cls_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

endmodule

>>> hdl/abpd_back.sv
// ----------------------------------------------------------------------------
// abpd_back: bit resolver, byte framer and packet assembler
// Turns one classified interval into up to four results, then hands them
// out one beat per cycle while the receiver is ready, from a small result buffer.
// ----------------------------------------------------------------------------
module abpd_back import abpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [5:0]  pre_min,
	input  logic [5:0]  pre_max,
	input  logic        q_empty,
	input  cls_t        q_data,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	typedef struct packed {
		logic        hop;
		logic        sp;
		logic [2:0]  sc;
		bphase_t     bp;
		logic [3:0]  bpos;
		logic [7:0]  shift;
		logic        par;
		pphase_t     pp;
		logic [5:0]  pre;
		logic [4:0]  bcnt;
		logic [4:0]  len;
		logic [7:0]  hdr;
		logic [7:0]  chk;
	} st_t;

	typedef struct packed {
		st_t             st;
		err_t            err;
		logic [2:0]      n;
		res_t [3:0]      res;
	} dec_t;

	function automatic st_t st_reset();
		st_t s;
		s = '0;
		s.bp  = BP_START;
		s.pp  = PP_PRE;
		s.par = 1'b1;
		return s;
	endfunction

	function automatic logic [4:0] length_of(logic [7:0] h);
		logic [7:0] n;
		if (h <= 8'h1F) begin
			n = 8'd1;
		end else if (h <= 8'h7F) begin
			n = h >> 4;
		end else if (h <= 8'hDF) begin
			n = (h >> 3) - 8'd8;
		end else begin
			n = (h >> 2) - 8'd36;
		end
		n = n + 8'd2;
		if (n > 8'(MAX_PACKET_BYTES)) begin
			n = 8'(MAX_PACKET_BYTES);
		end
		return n[4:0];
	endfunction

	function automatic dec_t emit(dec_t din, kind_t k, logic [7:0] v, logic [4:0] i,
		logic [4:0] l, logic [7:0] h, err_t c);
		dec_t d;
		d = din;
		if (d.n < 3'd4) begin
			d.res[d.n[1:0]] = '{kind: k, val: v, idx: i, len: l, hdr: h, code: c,
				last: 1'b0};
			d.n = d.n + 3'd1;
		end
		return d;
	endfunction

	function automatic dec_t take_byte(dec_t din);
		dec_t       d;
		logic [7:0] v;
		logic [4:0] idx;
		d   = din;
		v   = d.st.shift;
		idx = d.st.bcnt;
		case (d.st.pp)
			PP_HDR: begin
				d.st.hdr  = v;
				d.st.len  = length_of(v);
				d.st.chk  = v;
				d.st.bcnt = 5'd1;
				d.st.pp   = PP_MSG;
				d = emit(d, K_BYTE, v, 5'd0, d.st.len, d.st.hdr, E_NONE);
			end
			PP_MSG: begin
				d.st.chk  = d.st.chk ^ v;
				d.st.bcnt = idx + 5'd1;
				if (d.st.bcnt == d.st.len - 5'd1) begin
					d.st.pp = PP_CHK;
				end
				d = emit(d, K_BYTE, v, idx, d.st.len, d.st.hdr, E_NONE);
			end
			PP_CHK: begin
				d.st.bcnt = idx + 5'd1;
				d = emit(d, K_BYTE, v, idx, d.st.len, d.st.hdr, E_NONE);
				if (d.st.chk != v) begin
					d.err = E_PRECHK;
				end else begin
					d = emit(d, K_GOOD, 8'd0, d.st.bcnt, d.st.len, d.st.hdr, E_NONE);
					d.st = st_reset();
				end
			end
			default: begin
			end
		endcase
		return d;
	endfunction

	function automatic dec_t take_bit(dec_t din, logic b, logic [5:0] pmin,
		logic [5:0] pmax);
		dec_t d;
		logic go;
		d  = din;
		go = (d.err == E_NONE);
		if (go && d.st.pp == PP_PRE) begin
			if (b) begin
				if (d.st.pre != 6'd63) begin
					d.st.pre = d.st.pre + 6'd1;
				end
				if (d.st.pre > pmax) begin
					d.err = E_PRECHK;
				end
				go = 1'b0;
			end else if (d.st.pre < pmin) begin
				d.err = E_PRECHK;
				go    = 1'b0;
			end else begin
				d.st.pp = PP_HDR;
				d.st.bp = BP_START;
				d = emit(d, K_HDR, 8'd0, 5'd0, 5'd0, 8'd0, E_NONE);
			end
		end
		if (go) begin
			case (d.st.bp)
				BP_START: begin
					if (!b) begin
						d.st.bpos  = 4'd0;
						d.st.shift = 8'd0;
						d.st.par   = 1'b1;
						d.st.bp    = BP_DATA;
					end else begin
						d.err = E_START;
					end
				end
				BP_DATA: begin
					d.st.shift = d.st.shift | (8'(b) << d.st.bpos[2:0]);
					d.st.par   = d.st.par ^ b;
					d.st.bpos  = d.st.bpos + 4'd1;
					if (d.st.bpos >= 4'd8) begin
						d.st.bp = BP_PARITY;
					end
				end
				BP_PARITY: begin
					if (b == d.st.par) begin
						d.st.bp = BP_STOP;
					end else begin
						d.err = E_PARITY;
					end
				end
				default: begin
					if (b) begin
						d.st.bp = BP_START;
						d = take_byte(d);
					end else begin
						d.err = E_STOP;
					end
				end
			endcase
		end
		return d;
	endfunction

	function automatic dec_t resolve_one(dec_t din, logic [5:0] pmin, logic [5:0] pmax);
		dec_t d;
		d = din;
		d.st.hop = 1'b0;
		d.st.sp  = 1'b0;
		return take_bit(d, 1'b1, pmin, pmax);
	endfunction

	st_t        st_q;
	res_t [3:0] res_q;
	logic [2:0] rem_q;
	logic [1:0] rd_q;
	dec_t       d;
	logic       take_out;
	logic       can_load;
	res_t       r;

	assign take_out = m_tvalid && m_tready;
	assign can_load = (rem_q == 3'd0) || (rem_q == 3'd1 && take_out);
	assign q_pop    = can_load && !q_empty;

	always_comb begin
		d     = '0;
		d.st  = st_q;
		d.err = E_NONE;
		if (st_q.pp == PP_CHK && st_q.bp == BP_STOP) begin
			// Final stop bit: the width is not looked at.
			if (d.st.hop || d.st.sp) begin
				d = resolve_one(d, pre_min, pre_max);
			end else begin
				d.st.hop = 1'b1;
			end
		end else begin
			case (q_data.cls)
				CL_LONG: begin
					d.err = E_LONG;
				end
				CL_ZERO: begin
					if (d.st.pp == PP_PRE) begin
						d.st.hop = 1'b0;
						d.st.sp  = 1'b0;
						d = take_bit(d, 1'b0, pre_min, pre_max);
					end else if (d.st.hop) begin
						d.err = E_HALF;
					end else begin
						if (d.st.sp) begin
							if (d.st.sc == 3'd1) begin
								d.st.sp = 1'b0;
								d = take_bit(d, 1'b0, pre_min, pre_max);
							end else if (d.st.sc == 3'd2) begin
								d.st.sp = 1'b0;
								d = take_bit(d, 1'b1, pre_min, pre_max);
							end else if (d.st.sc == 3'd3) begin
								d.st.sp = 1'b0;
								d = take_bit(d, 1'b0, pre_min, pre_max);
								d = take_bit(d, 1'b1, pre_min, pre_max);
							end
						end
						d = take_bit(d, 1'b0, pre_min, pre_max);
					end
				end
				CL_UNC: begin
					if (d.st.bp == BP_START || d.st.pp == PP_PRE) begin
						if (q_data.above_start) begin
							d.st.hop = 1'b0;
							d.st.sp  = 1'b0;
							d = take_bit(d, 1'b0, pre_min, pre_max);
						end else if (d.st.hop || d.st.sp) begin
							d = resolve_one(d, pre_min, pre_max);
						end else begin
							d.st.sp = 1'b1;
							d.st.sc = 3'd1;
						end
					end else if (d.st.hop) begin
						d = resolve_one(d, pre_min, pre_max);
					end else if (d.st.sp) begin
						d.st.sc = d.st.sc + 3'd1;
						if (d.st.sc >= 3'd4) begin
							d.st.hop = 1'b0;
							d.st.sc  = d.st.sc - 3'd2;
							d = take_bit(d, 1'b1, pre_min, pre_max);
						end
					end else begin
						d.st.sp = 1'b1;
						d.st.sc = 3'd1;
					end
				end
				CL_HALF: begin
					if (d.st.hop) begin
						d = resolve_one(d, pre_min, pre_max);
					end else if (d.st.sp) begin
						if (d.st.sc == 3'd1) begin
							d.st.sp = 1'b0;
							d = take_bit(d, 1'b1, pre_min, pre_max);
						end else if (d.st.sc == 3'd2) begin
							d.st.sp = 1'b0;
							d = take_bit(d, 1'b0, pre_min, pre_max);
							d = take_bit(d, 1'b1, pre_min, pre_max);
						end else if (d.st.sc == 3'd3) begin
							d.st.sp = 1'b0;
							d = take_bit(d, 1'b1, pre_min, pre_max);
							d = take_bit(d, 1'b1, pre_min, pre_max);
						end
					end else begin
						d.st.hop = 1'b1;
					end
				end
				default: begin
					d.err = E_SHORT;
				end
			endcase
		end
		if (d.err != E_NONE) begin
			if (d.n >= 3'd4) begin
				d.n = 3'd3;
			end
			d = emit(d, K_ERR, 8'd0, d.st.bcnt, d.st.len, d.st.hdr, d.err);
			d.st = st_reset();
		end
		if (d.n != 3'd0) begin
			d.res[2'(d.n - 3'd1)].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= st_reset();
			rem_q <= 3'd0;
			rd_q  <= 2'd0;
		end else if (q_pop) begin
			st_q  <= d.st;
			rem_q <= d.n;
			rd_q  <= 2'd0;
		end else if (take_out) begin
			rem_q <= rem_q - 3'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= d.res;
		end
	end

	assign r        = res_q[rd_q];
	assign m_tvalid = (rem_q != 3'd0);
	assign m_tdata  = {3'd0, r.code, r.hdr, r.len, r.idx, r.val};
	assign m_tuser  = r.kind;
	assign m_tlast  = r.last;

endmodule

>>> tb/sv/tb_ask_biphase_packet_decoder.sv
// ----------------------------------------------------------------------------
// tb_ask_biphase_packet_decoder: self-checking bench of the bi-phase decoder
// Streams edge intervals (boundary widths, encoded packets, error cases and
// noise) through the block under several threshold settings, predicts every
// result beat in a cycle-free software model of the decoder and compares the
// result stream beat by beat while both sides stall at random.
// ----------------------------------------------------------------------------
module tb_ask_biphase_packet_decoder;
	import abpd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	ask_biphase_packet_decoder DUT (.*);

	// Intervals waiting to be offered, and result beats still to come.
	logic [15:0] interval_q[$];
	res_t        want_q[$];

	// Widths on both sides of every default class boundary.
	logic [15:0] bound_w [12] = '{16'd0, 16'd98, 16'd99, 16'd336, 16'd337, 16'd405,
		16'd406, 16'd449, 16'd450, 16'd900, 16'd901, 16'hFFFF};

	int snd_idle_pct = 13;
	int rcv_idle_pct = 68;
	int hold_left = 0;
	int fail_count = 0;

	// Threshold copy used by the predictor; it tracks every register write.
	logic [15:0] th_zmax = ZERO_MAX_RST, th_zmin = ZERO_MIN_RST;
	logic [15:0] th_smin = START_MIN_RST, th_hmax = HALF_MAX_RST;
	logic [15:0] th_hmin = HALF_MIN_RST;
	logic [5:0]  th_pmin = PRE_MIN_RST, th_pmax = PRE_MAX_RST;

	// Decoder state as the predictor sees it.
	logic        half_pend, susp_pend;
	logic [2:0]  susp_cnt;
	bphase_t     bph;
	logic [3:0]  bit_pos;
	logic [7:0]  shreg;
	logic        par;
	pphase_t     pph;
	logic [5:0]  pre_cnt;
	logic [4:0]  bcnt, plen;
	logic [7:0]  hdr_r, csum;
	err_t        fault;
	res_t        step_q[$];

	initial forever #6 clk = ~clk;

	function automatic void clear_decoder();
		half_pend = 0; susp_pend = 0; susp_cnt = 0;
		bph = BP_START; bit_pos = 0; shreg = 0; par = 1;
		pph = PP_PRE; pre_cnt = 0; bcnt = 0; plen = 0; hdr_r = 0; csum = 0;
	endfunction

	function automatic void add_beat(kind_t k, logic [7:0] v, logic [4:0] i, err_t c);
		res_t r;
		if (step_q.size() >= 4) return;
		r.kind = k; r.val = v; r.idx = i; r.code = c; r.last = 1'b0;
		// The header start carries no packet context at all.
		r.len = (k == K_HDR) ? 5'd0 : plen;
		r.hdr = (k == K_HDR) ? 8'd0 : hdr_r;
		step_q.push_back(r);
	endfunction

	function automatic logic [4:0] length_from_header(logic [7:0] h);
		int n;
		if (h <= 8'h1F) n = 1;
		else if (h <= 8'h7F) n = h >> 4;
		else if (h <= 8'hDF) n = (h >> 3) - 8;
		else n = (h >> 2) - 36;
		n += 2;
		if (n > MAX_PACKET_BYTES) n = MAX_PACKET_BYTES;
		return n[4:0];
	endfunction

	function automatic void finish_byte();
		logic [4:0] i;
		case (pph)
			PP_HDR: begin
				hdr_r = shreg; plen = length_from_header(shreg);
				csum = shreg; bcnt = 1; pph = PP_MSG;
				add_beat(K_BYTE, shreg, 5'd0, E_NONE);
			end
			PP_MSG: begin
				csum ^= shreg; i = bcnt; bcnt = i + 5'd1;
				if (int'(bcnt) == int'(plen) - 1) pph = PP_CHK;
				add_beat(K_BYTE, shreg, i, E_NONE);
			end
			PP_CHK: begin
				i = bcnt; bcnt = i + 5'd1;
				add_beat(K_BYTE, shreg, i, E_NONE);
				if (csum != shreg) fault = E_PRECHK;
				else begin
					add_beat(K_GOOD, 8'd0, bcnt, E_NONE);
					clear_decoder();
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void take_bit(logic b);
		if (fault != E_NONE) return;
		if (pph == PP_PRE) begin
			if (b) begin
				if (pre_cnt < 6'd63) pre_cnt++;
				if (pre_cnt > th_pmax) fault = E_PRECHK;
				return;
			end
			if (pre_cnt < th_pmin) begin
				fault = E_PRECHK;
				return;
			end
			pph = PP_HDR; bph = BP_START;
			add_beat(K_HDR, 8'd0, 5'd0, E_NONE);
		end
		case (bph)
			BP_START: begin
				if (!b) begin
					bit_pos = 0; shreg = 0; par = 1; bph = BP_DATA;
				end else fault = E_START;
			end
			BP_DATA: begin
				shreg[bit_pos[2:0]] = shreg[bit_pos[2:0]] | b;
				par ^= b;
				bit_pos++;
				if (bit_pos >= 4'd8) bph = BP_PARITY;
			end
			BP_PARITY: begin
				if (b == par) bph = BP_STOP;
				else fault = E_PARITY;
			end
			default: begin
				if (b) begin
					bph = BP_START;
					finish_byte();
				end else fault = E_STOP;
			end
		endcase
	endfunction

	function automatic void resolve_one();
		half_pend = 0; susp_pend = 0;
		take_bit(1);
	endfunction

	// Width classes are tested in a fixed order, whatever the thresholds are.
	function automatic void classify(logic [15:0] w);
		if (w > th_zmax) fault = E_LONG;
		else if (w >= th_zmin) begin
			if (pph == PP_PRE) begin
				half_pend = 0; susp_pend = 0; take_bit(0);
			end else if (half_pend) fault = E_HALF;
			else begin
				if (susp_pend) begin
					if (susp_cnt == 1) begin susp_pend = 0; take_bit(0); end
					else if (susp_cnt == 2) begin susp_pend = 0; take_bit(1); end
					else if (susp_cnt == 3) begin
						susp_pend = 0; take_bit(0); take_bit(1);
					end
				end
				take_bit(0);
			end
		end else if (w >= th_hmax) begin
			if (bph == BP_START || pph == PP_PRE) begin
				if (w > th_smin) begin
					half_pend = 0; susp_pend = 0; take_bit(0);
				end else if (half_pend || susp_pend) resolve_one();
				else begin
					susp_pend = 1; susp_cnt = 1;
				end
			end else if (half_pend) resolve_one();
			else if (susp_pend) begin
				susp_cnt++;
				if (susp_cnt >= 3'd4) begin
					half_pend = 0; susp_cnt -= 3'd2; take_bit(1);
				end
			end else begin
				susp_pend = 1; susp_cnt = 1;
			end
		end else if (w >= th_hmin) begin
			if (half_pend) resolve_one();
			else if (susp_pend) begin
				if (susp_cnt == 1) begin susp_pend = 0; take_bit(1); end
				else if (susp_cnt == 2) begin susp_pend = 0; take_bit(0); take_bit(1); end
				else if (susp_cnt == 3) begin susp_pend = 0; take_bit(1); take_bit(1); end
			end else half_pend = 1;
		end else fault = E_SHORT;
	endfunction

	// Works out the result beats of one accepted interval.
	function automatic void predict_interval(logic [15:0] w);
		step_q.delete();
		fault = E_NONE;
		// The checksum's stop bit is taken from the next two intervals blindly.
		if (pph == PP_CHK && bph == BP_STOP) begin
			if (half_pend || susp_pend) resolve_one();
			else half_pend = 1;
		end else classify(w);
		if (fault != E_NONE) begin
			if (step_q.size() >= 4) void'(step_q.pop_back());
			add_beat(K_ERR, 8'd0, bcnt, fault);
			clear_decoder();
		end
		if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
		foreach (step_q[k]) want_q.push_back(step_q[k]);
	endfunction

	// Sender: the interval beat is predicted at the edge that accepts it.
	always @(posedge clk) begin
		logic [15:0] nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready) predict_interval(s_tdata);
			if (s_tvalid && !s_tready) begin
				// Hold the beat until it is taken.
			end else if (interval_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
				nxt = interval_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= nxt;
			end else s_tvalid <= 1'b0;
		end
	end

	// Receiver: checks each result beat against the oldest prediction.
	always @(posedge clk) begin
		res_t w;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (want_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat tdata=%h tuser=%0d", m_tdata, m_tuser);
				end else begin
					w = want_q.pop_front();
					if (m_tuser != w.kind || m_tdata[7:0] != w.val ||
						m_tdata[12:8] != w.idx || m_tdata[17:13] != w.len ||
						m_tdata[25:18] != w.hdr || m_tdata[28:26] != w.code ||
						m_tdata[31:29] != 3'd0 || m_tlast != w.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: want kind=%0d val=%h idx=%0d len=%0d hdr=%h code=%0d last=%0b, got kind=%0d tdata=%h last=%0b",
								w.kind, w.val, w.idx, w.len, w.hdr, w.code, w.last,
								m_tuser, m_tdata, m_tlast);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else m_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// ---- Stimulus helpers -------------------------------------------------
	// A zero bit is one full interval, a one bit is two half intervals.
	function automatic void put_bit(logic b);
		if (b) begin
			interval_q.push_back(16'($urandom_range(110, 320)));
			interval_q.push_back(16'($urandom_range(110, 320)));
		end else interval_q.push_back(16'($urandom_range(460, 890)));
	endfunction

	function automatic void put_byte(logic [7:0] v, logic bad_parity);
		put_bit(0);
		for (int k = 0; k < 8; k++) put_bit(v[k]);
		put_bit(~^v ^ bad_parity);
		put_bit(1);
	endfunction

	function automatic void put_packet(int pre_lo, int pre_hi, logic bad_sum);
		logic [7:0] h, sum, b;
		int n;
		n = $urandom_range(99);
		if (n < 80) h = 8'($urandom_range(0, 8'h1F));
		else if (n < 95) h = 8'($urandom_range(8'h20, 8'h3F));
		else h = 8'($urandom_range(0, 255));
		repeat ($urandom_range(pre_lo, pre_hi)) put_bit(1);
		put_byte(h, 0);
		sum = h;
		for (int k = 2; k < length_from_header(h); k++) begin
			b = 8'($urandom_range(0, 255));
			sum ^= b;
			put_byte(b, 0);
		end
		put_byte(sum ^ {7'd0, bad_sum}, 0);
	endfunction

	// Mostly clean packets, some corrupted, the rest random noise. The
	// stream is cut to the requested number of intervals.
	task automatic random_traffic(int count, int pre_lo, int pre_hi);
		int start_size, pick, pos;
		start_size = interval_q.size();
		while (interval_q.size() - start_size < count) begin
			pick = $urandom_range(99);
			if (pick < 55) put_packet(pre_lo, pre_hi, 0);
			else if (pick < 70) begin
				pos = interval_q.size();
				put_packet(pre_lo, pre_hi, $urandom_range(1));
				pos += $urandom_range(interval_q.size() - pos - 1);
				interval_q[pos] = 16'($urandom_range(0, 1000));
			end else repeat ($urandom_range(1, 5)) begin
				if ($urandom_range(1)) interval_q.push_back(16'($urandom_range(0, 65535)));
				else interval_q.push_back(16'($urandom_range(0, 1000)));
			end
		end
		while (interval_q.size() > start_size + count) void'(interval_q.pop_back());
	endtask

	task automatic drain();
		while (interval_q.size() > 0 || s_tvalid || want_q.size() > 0) @(posedge clk);
		// Pending half ones cause no beat; let the pipeline settle.
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (r)
			R_ZERO_MAX:  th_zmax = v;
			R_ZERO_MIN:  th_zmin = v;
			R_START_MIN: th_smin = v;
			R_HALF_MAX:  th_hmax = v;
			R_HALF_MIN:  th_hmin = v;
			R_PRE_MIN:   th_pmin = v[5:0];
			R_PRE_MAX:   th_pmax = v[5:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [15:0] zmax, logic [15:0] zmin, logic [15:0] smin,
		logic [15:0] hmax, logic [15:0] hmin, logic [5:0] pmin, logic [5:0] pmax);
		write_reg(R_ZERO_MAX, zmax);
		write_reg(R_ZERO_MIN, zmin);
		write_reg(R_START_MIN, smin);
		write_reg(R_HALF_MAX, hmax);
		write_reg(R_HALF_MIN, hmin);
		write_reg(R_PRE_MIN, {10'd0, pmin});
		write_reg(R_PRE_MAX, {10'd0, pmax});
	endtask

	// ---- Main sequence ----------------------------------------------------
	initial begin
		clear_decoder();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: width class boundaries at the default thresholds, both
		// extremes of the field, then a clean packet and framing faults.
		foreach (bound_w[k]) interval_q.push_back(bound_w[k]);
		repeat (5) put_bit(1);
		put_byte(8'h10, 0);
		put_byte(8'hA5, 0);
		put_byte(8'hB5, 0);
		// A half one followed by a full zero inside a byte is misplaced.
		repeat (5) put_bit(1);
		put_bit(0); put_bit(1);
		interval_q.push_back(16'd200);
		interval_q.push_back(16'd600);
		// Parity fault, then a start bit of one after a good header.
		repeat (5) put_bit(1);
		put_byte(8'h05, 1);
		repeat (5) put_bit(1);
		put_byte(8'h05, 0);
		put_bit(1);
		// Stop bit of zero; an uncertain width in the start phase.
		repeat (5) put_bit(1);
		put_bit(0);
		repeat (8) put_bit(0);
		put_bit(1);
		put_bit(0);
		interval_q.push_back(16'd0);
		repeat (3) interval_q.push_back(16'd360);
		interval_q.push_back(16'd600);
		drain();

		// Degenerate thresholds at both extremes.
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 6'd63);
		random_traffic(5, 1, 4);
		drain();
		write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 6'd0, 6'd0);
		random_traffic(5, 0, 3);
		drain();

		// Defaults with the widest preamble window; the receiver now stalls
		// rarely, apart from one long hold-off that backs up the input.
		snd_idle_pct = 68;
		rcv_idle_pct = 13;
		write_all(ZERO_MAX_RST, ZERO_MIN_RST, START_MIN_RST, HALF_MAX_RST,
			HALF_MIN_RST, 6'd0, 6'd63);
		random_traffic(16, 0, 70);
		@(posedge clk);
		hold_left <= 300;
		drain();

		// Narrow preamble window, no idling on either side.
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		write_reg(R_PRE_MIN, 16'd3);
		write_reg(R_PRE_MAX, 16'd8);
		random_traffic(8, 1, 12);
		drain();
		repeat (20) @(posedge clk);

		if (fail_count == 0 && want_q.size() == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
